// ===== rtl/tpbs_pkg.sv =====
package tpbs_pkg;

	// default parameter values
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// bin code field widths and guard
	localparam int          X_BITS  = 11;
	localparam int          Y_BITS  = 11;
	localparam int          Z_BITS  = 10;
	localparam logic [31:0] Z_GUARD = 32'h0000_0200;

	// arithmetic widths
	localparam int ED_W = 33;   // edge vector component
	localparam int PR_W = 66;   // edge product
	localparam int CR_W = 67;   // cross product component
	localparam int LN_W = 7;    // bit length of a cross component
	localparam int M_W  = 24;   // normalized magnitude
	localparam int SQ_W = 63;   // square root working width
	localparam int R_W  = 31;   // root
	localparam int Q_W  = 31;   // quotient
	localparam int NSQ  = 31;   // square root stages
	localparam int NDV  = 31;   // divider stages

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_X_OFFSET = 3'd0,
		REG_Y_OFFSET = 3'd1,
		REG_Z_OFFSET = 3'd2,
		REG_X_SCALE  = 3'd3,
		REG_Y_SCALE  = 3'd4,
		REG_Z_SCALE  = 3'd5
	} cfg_reg_t;

	// front end result: codes, first point, edge flags and cross product
	typedef struct packed {
		logic                       is_tri;
		logic [31:0]                min_code;
		logic [31:0]                max_code;
		logic [2:0][31:0]           p1;
		logic [2:0]                 xmaj;
		logic [2:0][CR_W-1:0]       cr;
	} front_t;

	// data carried alongside the root and divider pipelines
	typedef struct packed {
		logic [31:0]                min_code;
		logic [31:0]                max_code;
		logic [2:0][31:0]           p1;
		logic [2:0]                 neg;
		logic                       nz;
		logic [2:0]                 xmaj;
		logic [2:0][M_W-1:0]        m;
	} side_t;

endpackage

// ===== rtl/triangle_plane_and_bin_code_setup.sv =====
// Triangle and segment setup: bounding-box bin codes, unit plane normal,
// plane offset and per-edge x-major flags.
//
// Input stream s_axis: one segment (tuser = 0) or triangle (tuser = 1) per
// transaction, nine Q16.16 coordinates in tdata. Output stream m_axis: one
// result transaction per input transaction, in order.
// Configuration: cfg_we / cfg_addr / cfg_wdata write the offset and scale
// registers; write them only while no transaction is in flight.
//
// Throughput: one transaction per cycle while the output buffer is not full.
// Pipeline: 3 front stages, 4 normalize stages, a 31-stage square root and
// a 31-stage divider (one bit per stage), 3 dot product stages and the
// output register.
// When the receiver stalls, a two-entry output buffer absorbs the result
// in flight and the whole pipeline then holds; s_axis_tready is driven from
// a register only. Reset clears all valid bits and sets offsets to 0 and
// scales to 1.0; the block takes input as soon as reset is released.
module triangle_plane_and_bin_code_setup #(
	parameter int COORD_WIDTH = tpbs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = tpbs_pkg::FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z
	input  logic [287:0] s_axis_tdata,
	// cmd
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// min_code, max_code, normal_a, normal_b, normal_c, plane_offset,
	// edge1_x_major, edge2_x_major, edge3_x_major, zero fill
	output logic [199:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_addr,
	input  logic [31:0]  cfg_wdata
);

	localparam int QW = tpbs_pkg::Q_W;

	// configuration registers
	logic [2:0][31:0] off_q, scl_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
			scl_q <= {3{32'h0001_0000}};
		end else if (cfg_we) begin
			case (tpbs_pkg::cfg_reg_t'(cfg_addr))
				tpbs_pkg::REG_X_OFFSET: off_q[0] <= cfg_wdata;
				tpbs_pkg::REG_Y_OFFSET: off_q[1] <= cfg_wdata;
				tpbs_pkg::REG_Z_OFFSET: off_q[2] <= cfg_wdata;
				tpbs_pkg::REG_X_SCALE:  scl_q[0] <= cfg_wdata;
				tpbs_pkg::REG_Y_SCALE:  scl_q[1] <= cfg_wdata;
				tpbs_pkg::REG_Z_SCALE:  scl_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// pipeline advance, held only while the output buffer is full
	logic en;
	logic skd_vld_q, out_vld_q;

	assign en            = !skd_vld_q;
	assign s_axis_tready = en;

	// front end
	logic [2:0][2:0][31:0] pt;
	logic                  fr_vld;
	tpbs_pkg::front_t      fr_data;

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				pt[i][k] = s_axis_tdata[(3*i+k)*32 +: 32];
	end

	tpbs_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.cmd       (s_axis_tuser),
		.pt        (pt),
		.offset    (off_q),
		.scale     (scl_q),
		.out_valid (fr_vld),
		.out_data  (fr_data)
	);

	// magnitude normalize and sum of squares
	logic                          nm_vld;
	logic [tpbs_pkg::SQ_W-1:0]     nm_v;
	tpbs_pkg::side_t               nm_side;

	tpbs_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_vld),
		.in_data   (fr_data),
		.out_valid (nm_vld),
		.out_v     (nm_v),
		.out_side  (nm_side)
	);

	// root
	logic                          sq_vld;
	logic [tpbs_pkg::R_W-1:0]      sq_root;
	tpbs_pkg::side_t               sq_side;

	tpbs_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (nm_vld),
		.in_v      (nm_v),
		.in_side   (nm_side),
		.out_valid (sq_vld),
		.out_root  (sq_root),
		.out_side  (sq_side)
	);

	// component division
	logic                    dv_vld;
	logic [2:0][QW-1:0]      dv_q;
	tpbs_pkg::side_t         dv_side;

	tpbs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_vld),
		.in_root   (sq_root),
		.in_side   (sq_side),
		.out_valid (dv_vld),
		.out_q     (dv_q),
		.out_side  (dv_side)
	);

	// dot stage 1: signed normal, zero when degenerate or a segment
	logic [2:0][31:0] nrm_w;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (!dv_side.nz)
				nrm_w[k] = '0;
			else if (dv_side.neg[k])
				nrm_w[k] = 32'(-{1'b0, dv_q[k]});
			else
				nrm_w[k] = {1'b0, dv_q[k]};
		end
	end

	logic             vld_s1, vld_s2, vld_s3;
	logic [2:0][31:0] nrm_s1, nrm_s2, nrm_s3;
	logic [2:0][31:0] p1_s1;
	logic [31:0]      minc_s1, maxc_s1, minc_s2, maxc_s2, minc_s3, maxc_s3;
	logic [2:0]       xm_s1, xm_s2, xm_s3;
	logic [2:0][63:0] pr_s2;
	logic [33:0]      po_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= dv_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	// dot stage 2: products with the first point
	logic [2:0][63:0] pr_w;

	always_comb begin
		for (int k = 0; k < 3; k++)
			pr_w[k] = $signed(nrm_s1[k]) * $signed(p1_s1[k]);
	end

	// dot stage 3: sum and floor shift
	logic [65:0] sum_w;

	assign sum_w = {{2{pr_s2[0][63]}}, pr_s2[0]} + {{2{pr_s2[1][63]}}, pr_s2[1]}
		+ {{2{pr_s2[2][63]}}, pr_s2[2]};

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_s1  <= nrm_w;
			p1_s1   <= dv_side.p1;
			minc_s1 <= dv_side.min_code;
			maxc_s1 <= dv_side.max_code;
			xm_s1   <= dv_side.xmaj;
			nrm_s2  <= nrm_s1;
			pr_s2   <= pr_w;
			minc_s2 <= minc_s1;
			maxc_s2 <= maxc_s1;
			xm_s2   <= xm_s1;
			nrm_s3  <= nrm_s2;
			po_s3   <= sum_w[63:30];
			minc_s3 <= minc_s2;
			maxc_s3 <= maxc_s2;
			xm_s3   <= xm_s2;
		end
	end

	logic [199:0] res_w;

	assign res_w = {3'b000, xm_s3, po_s3, nrm_s3[2], nrm_s3[1], nrm_s3[0], maxc_s3, minc_s3};

	// output register with skid entry
	logic [199:0] out_data_q, skd_data_q;
	logic         pop, push;

	assign pop  = out_vld_q && m_axis_tready;
	assign push = en && vld_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			skd_vld_q <= 1'b0;
		end else if (skd_vld_q) begin
			if (pop) skd_vld_q <= 1'b0;
		end else if (push) begin
			if (out_vld_q && !pop) skd_vld_q <= 1'b1;
			else out_vld_q <= 1'b1;
		end else if (pop) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skd_vld_q) begin
			if (pop) out_data_q <= skd_data_q;
		end else if (push) begin
			if (out_vld_q && !pop) skd_data_q <= res_w;
			else out_data_q <= res_w;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_data_q;

	// the skid entry is only used behind a full output register
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skd_vld_q |-> out_vld_q)
		else $error("skid entry valid with empty output register");

	// the skid entry fills only on a stalled output
	a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skd_vld_q) |-> $past(out_vld_q && !m_axis_tready))
		else $error("skid entry filled without a stall");

	// a zero normal always comes with a zero plane offset
	a_zero_normal_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_data_q[159:64] == 96'd0) |-> out_data_q[193:160] == 34'd0)
		else $error("plane offset nonzero for zero normal");

endmodule

// ===== rtl/tpbs_front.sv =====
module tpbs_front #(
	parameter int COORD_WIDTH = tpbs_pkg::COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = tpbs_pkg::FRAC_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic                   cmd,
	input  logic [2:0][2:0][31:0]  pt,       // [point][axis]
	input  logic [2:0][31:0]       offset,
	input  logic [2:0][31:0]       scale,
	output logic                   out_valid,
	output tpbs_pkg::front_t       out_data
);

	localparam int SW  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int SH  = 32 - SW;
	localparam int FSH = 2 * FRAC_BITS;
	localparam logic [63:0] X_MAX = 64'((1 << tpbs_pkg::X_BITS) - 1);
	localparam logic [63:0] Y_MAX = 64'((1 << tpbs_pkg::Y_BITS) - 1);
	localparam logic [63:0] Z_MAX = 64'((1 << tpbs_pkg::Z_BITS) - 1);

	// sign extension from the coordinate width
	function automatic logic [31:0] coord_ext(input logic [31:0] v);
		logic [31:0] t;
		t = v << SH;
		return 32'($signed(t) >>> SH);
	endfunction

	function automatic logic [32:0] abs33(input logic [32:0] v);
		return v[32] ? 33'(-v) : v;
	endfunction

	// stage 1: box, offsets and edges
	logic [2:0][2:0][31:0]            c_w;
	logic [2:0][31:0]                 lo_w, hi_w;
	logic [2:0][32:0]                 slo_w, shi_w;
	logic [2:0][2:0][tpbs_pkg::ED_W-1:0] e_w;

	always_comb begin
		for (int i = 0; i < 3; i++)
			for (int k = 0; k < 3; k++)
				c_w[i][k] = coord_ext(pt[i][k]);
		for (int k = 0; k < 3; k++) begin
			lo_w[k] = c_w[0][k];
			hi_w[k] = c_w[0][k];
			if ($signed(c_w[1][k]) < $signed(lo_w[k])) lo_w[k] = c_w[1][k];
			if ($signed(c_w[1][k]) > $signed(hi_w[k])) hi_w[k] = c_w[1][k];
			if (cmd && $signed(c_w[2][k]) < $signed(lo_w[k])) lo_w[k] = c_w[2][k];
			if (cmd && $signed(c_w[2][k]) > $signed(hi_w[k])) hi_w[k] = c_w[2][k];
			slo_w[k] = {lo_w[k][31], lo_w[k]} + {offset[k][31], offset[k]};
			shi_w[k] = {hi_w[k][31], hi_w[k]} + {offset[k][31], offset[k]};
			e_w[0][k] = {c_w[1][k][31], c_w[1][k]} - {c_w[0][k][31], c_w[0][k]};
			e_w[1][k] = {c_w[2][k][31], c_w[2][k]} - {c_w[1][k][31], c_w[1][k]};
			e_w[2][k] = {c_w[0][k][31], c_w[0][k]} - {c_w[2][k][31], c_w[2][k]};
		end
	end

	logic                                vld_s1;
	logic                                tri_s1;
	logic [2:0][32:0]                    slo_s1, shi_s1;
	logic [2:0][2:0][tpbs_pkg::ED_W-1:0] e_s1;
	logic [2:0][31:0]                    p1_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s1 <= cmd;
			slo_s1 <= slo_w;
			shi_s1 <= shi_w;
			e_s1   <= e_w;
			p1_s1  <= c_w[0];
		end
	end

	// stage 2: scale multiplies, cross products, edge flags
	logic [2:0][63:0]                prl_w, prh_w;
	logic [2:0]                      posl_w, posh_w;
	logic [2:0][tpbs_pkg::PR_W-1:0]  ca_w, cb_w;
	logic [2:0]                      xm_w;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			posl_w[k] = !slo_s1[k][32] && (slo_s1[k] != 33'd0);
			posh_w[k] = !shi_s1[k][32] && (shi_s1[k] != 33'd0);
			prl_w[k]  = 64'(slo_s1[k][31:0]) * 64'(scale[k]);
			prh_w[k]  = 64'(shi_s1[k][31:0]) * 64'(scale[k]);
			xm_w[k]   = tri_s1 && (abs33(e_s1[k][0]) > abs33(e_s1[k][1]));
		end
		ca_w[0] = $signed(e_s1[0][1]) * $signed(e_s1[1][2]);
		cb_w[0] = $signed(e_s1[1][1]) * $signed(e_s1[0][2]);
		ca_w[1] = $signed(e_s1[0][2]) * $signed(e_s1[1][0]);
		cb_w[1] = $signed(e_s1[1][2]) * $signed(e_s1[0][0]);
		ca_w[2] = $signed(e_s1[0][0]) * $signed(e_s1[1][1]);
		cb_w[2] = $signed(e_s1[1][0]) * $signed(e_s1[0][1]);
	end

	logic                            vld_s2;
	logic                            tri_s2;
	logic [2:0][63:0]                prl_s2, prh_s2;
	logic [2:0]                      posl_s2, posh_s2;
	logic [2:0][tpbs_pkg::PR_W-1:0]  ca_s2, cb_s2;
	logic [2:0]                      xm_s2;
	logic [2:0][31:0]                p1_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tri_s2  <= tri_s1;
			prl_s2  <= prl_w;
			prh_s2  <= prh_w;
			posl_s2 <= posl_w;
			posh_s2 <= posh_w;
			ca_s2   <= ca_w;
			cb_s2   <= cb_w;
			xm_s2   <= xm_w;
			p1_s2   <= p1_s1;
		end
	end

	// cell index with clamp to the field
	function automatic logic [10:0] bin_cell(input logic pos, input logic [63:0] pr,
		input logic [63:0] maxv);
		logic [63:0] q;
		q = pr >> FSH;
		if (!pos)
			return 11'd0;
		else if (q > maxv)
			return 11'(maxv);
		else
			return 11'(q);
	endfunction

	// stage 3: cross subtract, bin codes with guard
	logic [10:0]   cxl, cyl, cxh, cyh, czl11, czh11;
	logic [31:0]   minc_w, maxc_w;
	tpbs_pkg::front_t res_w;

	always_comb begin
		cxl   = bin_cell(posl_s2[0], prl_s2[0], X_MAX);
		cyl   = bin_cell(posl_s2[1], prl_s2[1], Y_MAX);
		czl11 = bin_cell(posl_s2[2], prl_s2[2], Z_MAX);
		cxh   = bin_cell(posh_s2[0], prh_s2[0], X_MAX);
		cyh   = bin_cell(posh_s2[1], prh_s2[1], Y_MAX);
		czh11 = bin_cell(posh_s2[2], prh_s2[2], Z_MAX);
		minc_w = {cxl, cyl, czl11[9:0]};
		maxc_w = {cxh, cyh, czh11[9:0]};
		if (tri_s2)
			minc_w = minc_w - tpbs_pkg::Z_GUARD;
		else
			maxc_w = maxc_w + tpbs_pkg::Z_GUARD;
		res_w.is_tri   = tri_s2;
		res_w.min_code = minc_w;
		res_w.max_code = maxc_w;
		res_w.p1       = p1_s2;
		res_w.xmaj     = xm_s2;
		for (int k = 0; k < 3; k++)
			res_w.cr[k] = {ca_s2[k][tpbs_pkg::PR_W-1], ca_s2[k]}
				- {cb_s2[k][tpbs_pkg::PR_W-1], cb_s2[k]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data <= res_w;
		end
	end

endmodule

// ===== rtl/tpbs_norm.sv =====
module tpbs_norm (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic                             in_valid,
	input  tpbs_pkg::front_t                 in_data,
	output logic                             out_valid,
	output logic [tpbs_pkg::SQ_W-1:0]        out_v,
	output tpbs_pkg::side_t                  out_side
);

	localparam int CW = tpbs_pkg::CR_W;
	localparam int MW = tpbs_pkg::M_W;
	localparam int LW = tpbs_pkg::LN_W;

	// stage 4: magnitudes and bit length of the largest
	logic [2:0][CW-1:0] mag_w;
	logic [2:0]         neg_w;
	logic [CW-1:0]      orv_w;
	logic [LW-1:0]      len_w;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			neg_w[k] = in_data.cr[k][CW-1];
			mag_w[k] = neg_w[k] ? CW'(-in_data.cr[k]) : in_data.cr[k];
		end
		orv_w = mag_w[0] | mag_w[1] | mag_w[2];
		len_w = '0;
		for (int i = 0; i < CW; i++)
			if (orv_w[i]) len_w = LW'(i + 1);
	end

	logic               vld_s4;
	logic [2:0][CW-1:0] mag_s4;
	logic [LW-1:0]      len_s4;
	logic [2:0]         neg_s4;
	logic               tri_s4;
	logic [31:0]        minc_s4, maxc_s4;
	logic [2:0][31:0]   p1_s4;
	logic [2:0]         xm_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4  <= mag_w;
			len_s4  <= len_w;
			neg_s4  <= neg_w;
			tri_s4  <= in_data.is_tri;
			minc_s4 <= in_data.min_code;
			maxc_s4 <= in_data.max_code;
			p1_s4   <= in_data.p1;
			xm_s4   <= in_data.xmaj;
		end
	end

	// stage 5: bring the leading one to the top of a 24-bit word
	logic [LW-1:0]      sh_w;
	logic [CW-1:0]      nrm_w [3];
	tpbs_pkg::side_t    sd_w;

	always_comb begin
		sh_w = LW'(CW) - len_s4;
		sd_w.min_code = minc_s4;
		sd_w.max_code = maxc_s4;
		sd_w.p1       = p1_s4;
		sd_w.neg      = neg_s4;
		sd_w.nz       = tri_s4 && (len_s4 != '0);
		sd_w.xmaj     = xm_s4;
		for (int k = 0; k < 3; k++) begin
			nrm_w[k]    = mag_s4[k] << sh_w;
			sd_w.m[k]   = nrm_w[k][CW-1 -: MW];
		end
	end

	logic            vld_s5;
	tpbs_pkg::side_t sd_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sd_s5 <= sd_w;
		end
	end

	// stage 6: squares
	logic [2:0][2*MW-1:0] sq_w;

	always_comb begin
		for (int k = 0; k < 3; k++)
			sq_w[k] = (2*MW)'(sd_s5.m[k]) * (2*MW)'(sd_s5.m[k]);
	end

	logic                 vld_s6;
	logic [2:0][2*MW-1:0] sq_s6;
	tpbs_pkg::side_t      sd_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s6 <= sq_w;
			sd_s6 <= sd_s5;
		end
	end

	// stage 7: sum of squares, scaled for the root
	logic [2*MW+1:0] sum_w;

	assign sum_w = (2*MW+2)'(sq_s6[0]) + (2*MW+2)'(sq_s6[1]) + (2*MW+2)'(sq_s6[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_v    <= tpbs_pkg::SQ_W'(sum_w) << 12;
			out_side <= sd_s6;
		end
	end

endmodule

// ===== rtl/tpbs_sqrt.sv =====
module tpbs_sqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [tpbs_pkg::SQ_W-1:0]    in_v,
	input  tpbs_pkg::side_t              in_side,
	output logic                         out_valid,
	output logic [tpbs_pkg::R_W-1:0]     out_root,
	output tpbs_pkg::side_t              out_side
);

	localparam int W  = tpbs_pkg::SQ_W;
	localparam int NS = tpbs_pkg::NSQ;

	// one result bit per stage, bit weight 4^(NS-1-g)
	logic [W-1:0]    rem_s  [NS];
	logic [W-1:0]    root_s [NS];
	logic            vld_s  [NS];
	tpbs_pkg::side_t side_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		localparam logic [W-1:0] BIT = W'(1) << (2 * (NS - 1 - g));
		logic [W-1:0]    rem_c, root_c, trial, rem_n, root_n;
		logic            vld_c;
		tpbs_pkg::side_t side_c;

		if (g == 0) begin : g_first
			assign rem_c  = in_v;
			assign root_c = '0;
			assign vld_c  = in_valid;
			assign side_c = in_side;
		end else begin : g_next
			assign rem_c  = rem_s[g-1];
			assign root_c = root_s[g-1];
			assign vld_c  = vld_s[g-1];
			assign side_c = side_s[g-1];
		end

		// compare against root + bit, subtract on success
		always_comb begin
			trial = root_c + BIT;
			if (rem_c >= trial) begin
				rem_n  = rem_c - trial;
				root_n = (root_c >> 1) + BIT;
			end else begin
				rem_n  = rem_c;
				root_n = root_c >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_n;
				root_s[g] <= root_n;
				side_s[g] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_root  = root_s[NS-1][tpbs_pkg::R_W-1:0];
	assign out_side  = side_s[NS-1];

endmodule

// ===== rtl/tpbs_div.sv =====
module tpbs_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [tpbs_pkg::R_W-1:0]          in_root,
	input  tpbs_pkg::side_t                   in_side,
	output logic                              out_valid,
	output logic [2:0][tpbs_pkg::Q_W-1:0]     out_q,
	output tpbs_pkg::side_t                   out_side
);

	localparam int NS = tpbs_pkg::NDV;
	localparam int RW = tpbs_pkg::R_W;
	localparam int QW = tpbs_pkg::Q_W;
	localparam int MW = tpbs_pkg::M_W;
	localparam int DW = RW + 1;

	// restoring division of m * 2^36 by the root, three lanes, one bit per stage;
	// the dividend's low bits are zero, so each step only shifts the remainder
	logic [2:0][DW-1:0] rem_s  [NS];
	logic [2:0][QW-1:0] quo_s  [NS];
	logic [RW-1:0]      dvs_s  [NS];
	logic               vld_s  [NS];
	tpbs_pkg::side_t    side_s [NS];

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [2:0][DW-1:0] rem_c, rem_n;
		logic [2:0][QW-1:0] quo_c, quo_n;
		logic [RW-1:0]      dvs_c;
		logic               vld_c;
		tpbs_pkg::side_t    side_c;
		logic [DW-1:0]      sh;

		if (g == 0) begin : g_first
			for (genvar k = 0; k < 3; k++) begin : g_lane
				assign rem_c[k] = DW'({in_side.m[k], 5'b0});
			end
			assign quo_c  = '0;
			assign dvs_c  = in_root;
			assign vld_c  = in_valid;
			assign side_c = in_side;
		end else begin : g_next
			assign rem_c  = rem_s[g-1];
			assign quo_c  = quo_s[g-1];
			assign dvs_c  = dvs_s[g-1];
			assign vld_c  = vld_s[g-1];
			assign side_c = side_s[g-1];
		end

		always_comb begin
			sh = '0;
			for (int k = 0; k < 3; k++) begin
				sh = rem_c[k] << 1;
				if (sh >= DW'(dvs_c)) begin
					rem_n[k] = sh - DW'(dvs_c);
					quo_n[k] = {quo_c[k][QW-2:0], 1'b1};
				end else begin
					rem_n[k] = sh;
					quo_n[k] = {quo_c[k][QW-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= vld_c;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g]  <= rem_n;
				quo_s[g]  <= quo_n;
				dvs_s[g]  <= dvs_c;
				side_s[g] <= side_c;
			end
		end
	end

	assign out_valid = vld_s[NS-1];
	assign out_q     = quo_s[NS-1];
	assign out_side  = side_s[NS-1];

endmodule
